// File: rtl/b64d_pkg.sv
// Shared types, constants and the character classifier of the base64 stream decoder.
// No dependencies.
package b64d_pkg;

	localparam int Q_DEPTH = 2;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	localparam logic [7:0] LOWER_BASE = 8'd26;
	localparam logic [7:0] DIGIT_BASE = 8'd52;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] SEXTET_ONES  = 6'h3F;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;
	localparam logic [1:0] POS_FOURTH = 2'd3;

	localparam logic [1:0] SLOT_FIRST  = 2'd0;
	localparam logic [1:0] SLOT_SECOND = 2'd1;
	localparam logic [1:0] SLOT_THIRD  = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} char_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] byte_slot;
	} byte_word_t;

	typedef struct packed {
		logic [1:0] slot;
		logic [5:0] prev;
		logic [5:0] cur;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t s;
		s.valid = 1'b1;
		s.value = SEXTET_ONES;
		if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
			s.value = 6'(ch - CH_UPPER_A);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
			s.value = 6'(ch - CH_LOWER_A + LOWER_BASE);
		end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
			s.value = 6'(ch - CH_DIGIT_0 + DIGIT_BASE);
		end else if (ch == CH_PLUS) begin
			s.value = SEXTET_PLUS;
		end else if (ch == CH_SLASH) begin
			s.value = SEXTET_SLASH;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

endpackage

// File: rtl/b64d_front.sv
// Front end: accepts characters, classifies them and tracks quartet position and halt.
// Depends on b64d_pkg.
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_word_t char_word,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [1:0] pos_q;
	logic [5:0] held_q;
	logic       halted_q;
	sextet_t    sx;
	logic [5:0] cur;
	logic       accept;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;
	assign sx         = sextet_of(char_word.char_code);
	assign cur        = sx.valid ? sx.value : SEXTET_ONES;

	assign push     = accept && !halted_q && sx.valid && (pos_q != POS_FIRST);
	assign push_cmd = '{slot: 2'(pos_q - 2'd1), prev: held_q, cur: cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_FIRST;
			held_q   <= '0;
			halted_q <= 1'b0;
		end else if (accept) begin
			if (char_word.end_of_text) begin
				pos_q    <= POS_FIRST;
				held_q   <= '0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (!sx.valid && (pos_q == POS_FIRST || pos_q == POS_SECOND)) begin
					halted_q <= 1'b1;
				end
				held_q <= cur;
				pos_q  <= 2'(pos_q + 2'd1);
			end
		end
	end

endmodule

// File: rtl/b64d_queue.sv
// Short command queue between the front end and the byte assembler.
// Depends on b64d_pkg.
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

endmodule

// File: rtl/b64d_back.sv
// Back end: assembles the byte from two sextets and holds it in the output register.
// Depends on b64d_pkg.
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  cmd_t       q_head,
	output logic       pop,
	output logic       byte_valid,
	input  logic       byte_stall,
	output byte_word_t byte_word
);

	logic       valid_q;
	byte_word_t word_q;
	logic [7:0] data;

	assign pop        = q_not_empty && (!valid_q || !byte_stall);
	assign byte_valid = valid_q;
	assign byte_word  = word_q;

	always_comb begin
		unique case (q_head.slot)
			SLOT_FIRST:  data = {q_head.prev, q_head.cur[5:4]};
			SLOT_SECOND: data = {q_head.prev[3:0], q_head.cur[5:2]};
			SLOT_THIRD:  data = {q_head.prev[1:0], q_head.cur};
			default:     data = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q.data_byte <= data;
			word_q.byte_slot <= q_head.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!byte_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: front end, command queue, byte assembler.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//   channel  | signals                                  | word
//   chars    | char_valid, char_stall, char_word        | char_code, end_of_text
//   bytes    | byte_valid, byte_stall, byte_word        | data_byte, byte_slot
//
// One character is taken each cycle while char_stall is low; a byte that it completes is
// queued at the edge that takes the character, then assembled into the output register when
// byte_stall allows. The rate is set by the classify-and-track step in the front end.
// char_stall rises only on a full queue, after byte_stall has held QUEUE_DEPTH + 1 bytes.
// Reset empties the queue and the output register and returns the quartet state to its start.
module base64_stream_decoder_unit
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = Q_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_word_t char_word,
	output logic       byte_valid,
	input  logic       byte_stall,
	output byte_word_t byte_word
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_not_empty;
	cmd_t q_head;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word)
	);

endmodule
